[src/wmit_pkg.sv]
package wmit_pkg;

  localparam int unsigned MAX_RUN_DEF     = 63;
  localparam int unsigned MAX_HEADING_DEF = 6;
  localparam int unsigned MAX_TOKENS      = 40;
  localparam int unsigned TOKCNT_W        = $clog2(MAX_TOKENS + 1);

  localparam logic [3:0] TK_LIT          = 4'd0;
  localparam logic [3:0] TK_PARA_OPEN    = 4'd1;
  localparam logic [3:0] TK_PARA_CLOSE   = 4'd2;
  localparam logic [3:0] TK_EM_OPEN      = 4'd3;
  localparam logic [3:0] TK_EM_CLOSE     = 4'd4;
  localparam logic [3:0] TK_STRONG_OPEN  = 4'd5;
  localparam logic [3:0] TK_STRONG_CLOSE = 4'd6;
  localparam logic [3:0] TK_BREAK        = 4'd7;
  localparam logic [3:0] TK_HEAD_OPEN    = 4'd8;
  localparam logic [3:0] TK_HEAD_CLOSE   = 4'd9;

  localparam logic [15:0] CH_EQ   = 16'h003D;
  localparam logic [15:0] CH_BSL  = 16'h005C;
  localparam logic [15:0] CH_SL   = 16'h002F;
  localparam logic [15:0] CH_STAR = 16'h002A;
  localparam logic [15:0] CH_NL   = 16'h000A;

  typedef enum logic [2:0] {
    SYM_NONE = 3'd0,
    SYM_EQ   = 3'd1,
    SYM_BSL  = 3'd2,
    SYM_SL   = 3'd3,
    SYM_STAR = 3'd4
  } sym_e;

  typedef enum logic [4:0] {
    OP_NONE       = 5'd0,
    OP_LOAD       = 5'd1,
    OP_EMIT_EQ    = 5'd2,
    OP_LIT_C      = 5'd3,
    OP_PARA_OPEN  = 5'd4,
    OP_HEAD_OPEN  = 5'd5,
    OP_HEAD_CLOSE = 5'd6,
    OP_LOAD_HELD  = 5'd7,
    OP_LOAD_PAIRS = 5'd8,
    OP_PAIR       = 5'd9,
    OP_RES_END    = 5'd10,
    OP_CLR_RUN    = 5'd11,
    OP_HELD_INC   = 5'd12,
    OP_RUN_INC    = 5'd13,
    OP_RUN_EQLOAD = 5'd14,
    OP_RUN_START  = 5'd15,
    OP_SEC        = 5'd16,
    OP_FINISH     = 5'd17
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic fol;
    logic is_nl;
    logic is_eq;
    logic is_marker;
    logic same_run;
    logic run_nz;
    logic run_is_eq;
    logic eq_over;
    logic heading_open;
    logic in_para;
    logic sec_last;
    logic cnt_zero;
    logic room0;
    logic room1;
    logic out_free;
  } status_t;

  function automatic sym_e classify(logic [15:0] c);
    sym_e s;
    s = SYM_NONE;
    if (c == CH_EQ) s = SYM_EQ;
    else if (c == CH_BSL) s = SYM_BSL;
    else if (c == CH_SL) s = SYM_SL;
    else if (c == CH_STAR) s = SYM_STAR;
    return s;
  endfunction

endpackage

[src/wmit_char_if.sv]
interface wmit_char_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic        first_of_line;

  modport source (output valid, output code_point, output first_of_line, input ready);
  modport sink (input valid, input code_point, input first_of_line, output ready);
endinterface

[src/wmit_tok_if.sv]
interface wmit_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_char;
  logic [2:0]  heading_level;
  logic        last;

  modport source (output valid, output token_kind, output token_char,
                  output heading_level, output last, input ready);
  modport sink (input valid, input token_kind, input token_char,
                input heading_level, input last, output ready);
endinterface

[src/wiki_markup_inline_tokenizer.sv]
// Inline wiki-markup tokenizer: takes one character per beat with a first-of-line flag and
// returns a stream of tokens (literals, paragraph, emphasis, strong, line break, heading
// open/close), the final token of each character flagged by last. One character is taken at
// a time, and the single sequencer that walks the tokenizer state handles it. A plain character
// passes through load, line-start check, paragraph check, body, emit and finish; a character
// that only extends a run, or that is held as '=' inside a heading, skips the emit step.
// Ending a marker run emits its pairs and then any odd marker left over, and opening a
// heading is a step of its own. Each held '=' released is a step, and so is each '=' of a run
// that grows past the heading limit. An empty line closes any open heading and then emits
// the close tokens of the open section in turn. A stalled output holds the sequencer.
// Each character yields at most 40 tokens; further tokens are dropped.
// A character that yields no token produces no output beat.
module wiki_markup_inline_tokenizer #(
  parameter int unsigned MAX_RUN     = wmit_pkg::MAX_RUN_DEF,
  parameter int unsigned MAX_HEADING = wmit_pkg::MAX_HEADING_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wmit_char_if.sink   char_i,
  wmit_tok_if.source  tok_o
);

  wmit_pkg::cmd_t    cmd;
  wmit_pkg::status_t status;

  wmit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ready_o (char_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wmit_dpath #(
    .MAX_RUN     (MAX_RUN),
    .MAX_HEADING (MAX_HEADING)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .code_point_i    (char_i.code_point),
    .first_of_line_i (char_i.first_of_line),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (tok_o.valid),
    .out_ready_i     (tok_o.ready),
    .token_kind_o    (tok_o.token_kind),
    .token_char_o    (tok_o.token_char),
    .heading_level_o (tok_o.heading_level),
    .last_o          (tok_o.last)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_i.valid && char_i.ready) |=> !char_i.ready)
    else $error("input taken while a character is in work");

  a_level_only_on_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.valid && tok_o.token_kind != wmit_pkg::TK_HEAD_OPEN &&
     tok_o.token_kind != wmit_pkg::TK_HEAD_CLOSE) |-> (tok_o.heading_level == '0))
    else $error("heading level on a non-heading token");

  a_char_only_on_literal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.valid && tok_o.token_kind != wmit_pkg::TK_LIT) |-> (tok_o.token_char == '0))
    else $error("character on a non-literal token");

endmodule

[src/wmit_ctrl.sv]
module wmit_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wmit_pkg::status_t status_i,
  output wmit_pkg::cmd_t    cmd_o
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_PRE      = 14'b00000000000010,
    ST_FLUSH0   = 14'b00000000000100,
    ST_NLHEAD   = 14'b00000000001000,
    ST_NLHCLOSE = 14'b00000000010000,
    ST_NLPAIRS  = 14'b00000000100000,
    ST_MAIN     = 14'b00000001000000,
    ST_SEC      = 14'b00000010000000,
    ST_BODY     = 14'b00000100000000,
    ST_PAIRS    = 14'b00001000000000,
    ST_NEW      = 14'b00010000000000,
    ST_EQLIT    = 14'b00100000000000,
    ST_FLUSH1   = 14'b01000000000000,
    ST_FIN      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  wmit_pkg::op_e op;

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o.op   = op;

  always_comb begin
    state_d = state_q;
    op      = wmit_pkg::OP_NONE;
    if (state_q != ST_IDLE && !status_i.out_free) begin
      // hold until the output slot frees up
      op = wmit_pkg::OP_NONE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op      = wmit_pkg::OP_LOAD;
            state_d = ST_PRE;
          end
        end
        ST_PRE: begin
          if (status_i.fol && status_i.heading_open) begin
            op      = wmit_pkg::OP_LOAD_HELD;
            state_d = ST_FLUSH0;
          end else if (status_i.fol && status_i.run_nz) begin
            if (status_i.run_is_eq) begin
              state_d = ST_NLHEAD;
            end else begin
              op      = wmit_pkg::OP_LOAD_PAIRS;
              state_d = ST_NLPAIRS;
            end
          end else begin
            if (status_i.fol) op = wmit_pkg::OP_CLR_RUN;
            state_d = ST_MAIN;
          end
        end
        ST_FLUSH0: begin
          if (status_i.cnt_zero || !status_i.room0) begin
            op      = wmit_pkg::OP_CLR_RUN;
            state_d = ST_MAIN;
          end else begin
            op = wmit_pkg::OP_EMIT_EQ;
          end
        end
        ST_NLHEAD: begin
          op      = wmit_pkg::OP_HEAD_OPEN;
          state_d = ST_NLHCLOSE;
        end
        ST_NLHCLOSE: begin
          op      = wmit_pkg::OP_HEAD_CLOSE;
          state_d = ST_MAIN;
        end
        ST_NLPAIRS: begin
          if (!status_i.cnt_zero) begin
            op = wmit_pkg::OP_PAIR;
          end else begin
            op      = wmit_pkg::OP_RES_END;
            state_d = ST_MAIN;
          end
        end
        ST_MAIN: begin
          if (status_i.fol && status_i.is_nl) begin
            if (status_i.heading_open) op = wmit_pkg::OP_HEAD_CLOSE;
            state_d = ST_SEC;
          end else begin
            if (!status_i.in_para) op = wmit_pkg::OP_PARA_OPEN;
            state_d = ST_BODY;
          end
        end
        ST_SEC: begin
          if (!status_i.in_para) begin
            state_d = ST_FIN;
          end else begin
            op = wmit_pkg::OP_SEC;
            if (status_i.sec_last) state_d = ST_FIN;
          end
        end
        ST_BODY: begin
          if (status_i.heading_open) begin
            if (status_i.is_nl) begin
              op      = wmit_pkg::OP_HEAD_CLOSE;
              state_d = ST_FIN;
            end else if (status_i.is_eq) begin
              op      = wmit_pkg::OP_HELD_INC;
              state_d = ST_FIN;
            end else begin
              op      = wmit_pkg::OP_LOAD_HELD;
              state_d = ST_FLUSH1;
            end
          end else if (status_i.same_run) begin
            if (status_i.is_eq && status_i.eq_over) begin
              op      = wmit_pkg::OP_RUN_EQLOAD;
              state_d = ST_EQLIT;
            end else begin
              op      = wmit_pkg::OP_RUN_INC;
              state_d = ST_FIN;
            end
          end else if (status_i.run_nz && status_i.run_is_eq) begin
            // heading opens, then this character is its first
            op = wmit_pkg::OP_HEAD_OPEN;
          end else if (status_i.run_nz) begin
            op      = wmit_pkg::OP_LOAD_PAIRS;
            state_d = ST_PAIRS;
          end else begin
            state_d = ST_NEW;
          end
        end
        ST_PAIRS: begin
          if (!status_i.cnt_zero) begin
            op = wmit_pkg::OP_PAIR;
          end else begin
            op      = wmit_pkg::OP_RES_END;
            state_d = ST_NEW;
          end
        end
        ST_NEW: begin
          state_d = ST_FIN;
          if (status_i.is_eq) begin
            op = status_i.fol ? wmit_pkg::OP_RUN_START : wmit_pkg::OP_LIT_C;
          end else if (status_i.is_marker) begin
            op = wmit_pkg::OP_RUN_START;
          end else if (!status_i.is_nl) begin
            op = wmit_pkg::OP_LIT_C;
          end
        end
        ST_EQLIT: begin
          if (!status_i.cnt_zero) begin
            op = wmit_pkg::OP_EMIT_EQ;
          end else begin
            op      = wmit_pkg::OP_CLR_RUN;
            state_d = ST_FIN;
          end
        end
        ST_FLUSH1: begin
          if (!status_i.cnt_zero && status_i.room1) begin
            op = wmit_pkg::OP_EMIT_EQ;
          end else begin
            op      = wmit_pkg::OP_LIT_C;
            state_d = ST_FIN;
          end
        end
        ST_FIN: begin
          op      = wmit_pkg::OP_FINISH;
          state_d = ST_IDLE;
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule

[src/wmit_dpath.sv]
module wmit_dpath #(
  parameter int unsigned MAX_RUN     = wmit_pkg::MAX_RUN_DEF,
  parameter int unsigned MAX_HEADING = wmit_pkg::MAX_HEADING_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       code_point_i,
  input  logic              first_of_line_i,
  input  wmit_pkg::cmd_t    cmd_i,
  output wmit_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        token_kind_o,
  output logic [15:0]       token_char_o,
  output logic [2:0]        heading_level_o,
  output logic              last_o
);

  localparam int unsigned RUN_W = $clog2(MAX_RUN + 1);
  localparam int unsigned TC_W  = wmit_pkg::TOKCNT_W;

  logic [15:0]        c_q, c_d;
  logic               fol_q, fol_d;
  wmit_pkg::sym_e     sym_q, sym_d, run_sym_q, run_sym_d;
  logic [RUN_W-1:0]   run_len_q, run_len_d, held_q, held_d, cnt_q, cnt_d;
  logic [1:0]         em_q, em_d, st_q, st_d;
  logic               para_q, para_d;
  logic [2:0]         head_q, head_d;
  logic [TC_W-1:0]    ocnt_q, ocnt_d;
  logic               pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic [3:0]         pend_kind_q, out_kind_q;
  logic [15:0]        pend_char_q, out_char_q;
  logic [2:0]         pend_lvl_q, out_lvl_q;
  logic               out_last_q;

  logic               emit, push, fin_push, out_free;
  logic [3:0]         t_kind;
  logic [15:0]        t_char;
  logic [2:0]         t_lvl;

  assign out_free = !out_v_q || out_ready_i;

  always_comb begin
    status_o.fol          = fol_q;
    status_o.is_nl        = (c_q == wmit_pkg::CH_NL);
    status_o.is_eq        = (sym_q == wmit_pkg::SYM_EQ);
    status_o.is_marker    = (sym_q != wmit_pkg::SYM_NONE);
    status_o.same_run     = (sym_q != wmit_pkg::SYM_NONE) && (sym_q == run_sym_q) &&
                            (run_len_q != '0);
    status_o.run_nz       = (run_len_q != '0) && (run_sym_q != wmit_pkg::SYM_NONE);
    status_o.run_is_eq    = (run_sym_q == wmit_pkg::SYM_EQ);
    status_o.eq_over      = (run_len_q >= RUN_W'(MAX_HEADING));
    status_o.heading_open = (head_q != '0);
    status_o.in_para      = para_q;
    status_o.sec_last     = (em_q == '0) && (st_q == '0);
    status_o.cnt_zero     = (cnt_q == '0);
    status_o.room0        = (ocnt_q < TC_W'(wmit_pkg::MAX_TOKENS));
    status_o.room1        = (ocnt_q < TC_W'(wmit_pkg::MAX_TOKENS - 1));
    status_o.out_free     = out_free;
  end

  always_comb begin
    c_d       = c_q;
    fol_d     = fol_q;
    sym_d     = sym_q;
    run_sym_d = run_sym_q;
    run_len_d = run_len_q;
    held_d    = held_q;
    cnt_d     = cnt_q;
    em_d      = em_q;
    st_d      = st_q;
    para_d    = para_q;
    head_d    = head_q;
    ocnt_d    = ocnt_q;
    emit      = 1'b0;
    fin_push  = 1'b0;
    t_kind    = wmit_pkg::TK_LIT;
    t_char    = '0;
    t_lvl     = '0;
    case (cmd_i.op)
      wmit_pkg::OP_LOAD: begin
        c_d    = code_point_i;
        fol_d  = first_of_line_i;
        sym_d  = wmit_pkg::classify(code_point_i);
        ocnt_d = '0;
      end
      wmit_pkg::OP_EMIT_EQ: begin
        emit   = 1'b1;
        t_char = wmit_pkg::CH_EQ;
        cnt_d  = cnt_q - 1'b1;
      end
      wmit_pkg::OP_LIT_C: begin
        emit   = 1'b1;
        t_char = c_q;
      end
      wmit_pkg::OP_PARA_OPEN: begin
        emit   = 1'b1;
        t_kind = wmit_pkg::TK_PARA_OPEN;
        para_d = 1'b1;
      end
      wmit_pkg::OP_HEAD_OPEN: begin
        emit      = 1'b1;
        t_kind    = wmit_pkg::TK_HEAD_OPEN;
        t_lvl     = (run_len_q >= RUN_W'(MAX_HEADING)) ? 3'(MAX_HEADING) : run_len_q[2:0];
        head_d    = t_lvl;
        held_d    = '0;
        run_sym_d = wmit_pkg::SYM_NONE;
        run_len_d = '0;
      end
      wmit_pkg::OP_HEAD_CLOSE: begin
        emit   = 1'b1;
        t_kind = wmit_pkg::TK_HEAD_CLOSE;
        t_lvl  = head_q;
        head_d = '0;
        held_d = '0;
      end
      wmit_pkg::OP_LOAD_HELD: begin
        cnt_d  = held_q;
        held_d = '0;
      end
      wmit_pkg::OP_LOAD_PAIRS: cnt_d = run_len_q >> 1;
      wmit_pkg::OP_PAIR: begin
        emit  = 1'b1;
        cnt_d = cnt_q - 1'b1;
        case (run_sym_q)
          wmit_pkg::SYM_BSL: t_kind = wmit_pkg::TK_BREAK;
          wmit_pkg::SYM_SL: begin
            if (em_q != '0) begin
              em_d   = '0;
              t_kind = wmit_pkg::TK_EM_CLOSE;
            end else begin
              em_d   = (st_q != '0) ? 2'd1 : 2'd2;
              t_kind = wmit_pkg::TK_EM_OPEN;
            end
          end
          default: begin
            if (st_q != '0) begin
              st_d   = '0;
              t_kind = wmit_pkg::TK_STRONG_CLOSE;
            end else begin
              st_d   = (em_q != '0) ? 2'd1 : 2'd2;
              t_kind = wmit_pkg::TK_STRONG_OPEN;
            end
          end
        endcase
      end
      wmit_pkg::OP_RES_END: begin
        emit = run_len_q[0];
        case (run_sym_q)
          wmit_pkg::SYM_BSL: t_char = wmit_pkg::CH_BSL;
          wmit_pkg::SYM_SL:  t_char = wmit_pkg::CH_SL;
          default:           t_char = wmit_pkg::CH_STAR;
        endcase
        run_sym_d = wmit_pkg::SYM_NONE;
        run_len_d = '0;
      end
      wmit_pkg::OP_CLR_RUN: begin
        run_sym_d = wmit_pkg::SYM_NONE;
        run_len_d = '0;
      end
      wmit_pkg::OP_HELD_INC: begin
        if (held_q < RUN_W'(MAX_RUN)) held_d = held_q + 1'b1;
      end
      wmit_pkg::OP_RUN_INC: begin
        if (run_len_q < RUN_W'(MAX_RUN)) run_len_d = run_len_q + 1'b1;
      end
      wmit_pkg::OP_RUN_EQLOAD: cnt_d = run_len_q + 1'b1;
      wmit_pkg::OP_RUN_START: begin
        run_sym_d = sym_q;
        run_len_d = RUN_W'(1);
      end
      wmit_pkg::OP_SEC: begin
        emit = 1'b1;
        if (em_q != '0 && em_q >= st_q) begin
          em_d   = '0;
          t_kind = wmit_pkg::TK_EM_CLOSE;
        end else if (st_q != '0) begin
          st_d   = '0;
          t_kind = wmit_pkg::TK_STRONG_CLOSE;
        end else begin
          para_d = 1'b0;
          t_kind = wmit_pkg::TK_PARA_CLOSE;
        end
      end
      wmit_pkg::OP_FINISH: fin_push = pend_v_q;
      default: ;
    endcase
    // tokens past the per-character budget are dropped
    push = emit && (ocnt_q < TC_W'(wmit_pkg::MAX_TOKENS));
    if (push) ocnt_d = ocnt_q + 1'b1;
  end

  always_comb begin
    pend_v_d = pend_v_q;
    out_v_d  = out_v_q && !out_ready_i;
    if (push) begin
      pend_v_d = 1'b1;
      if (pend_v_q) out_v_d = 1'b1;
    end
    if (fin_push) begin
      pend_v_d = 1'b0;
      out_v_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sym_q <= wmit_pkg::SYM_NONE;
      run_len_q <= '0;
      held_q    <= '0;
      em_q      <= '0;
      st_q      <= '0;
      para_q    <= 1'b0;
      head_q    <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      run_sym_q <= run_sym_d;
      run_len_q <= run_len_d;
      held_q    <= held_d;
      em_q      <= em_d;
      st_q      <= st_d;
      para_q    <= para_d;
      head_q    <= head_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    fol_q  <= fol_d;
    sym_q  <= sym_d;
    cnt_q  <= cnt_d;
    ocnt_q <= ocnt_d;
    if (push) begin
      pend_kind_q <= t_kind;
      pend_char_q <= t_char;
      pend_lvl_q  <= t_lvl;
    end
    if ((push && pend_v_q) || fin_push) begin
      out_kind_q <= pend_kind_q;
      out_char_q <= pend_char_q;
      out_lvl_q  <= pend_lvl_q;
      out_last_q <= fin_push;
    end
  end

  assign out_valid_o     = out_v_q;
  assign token_kind_o    = out_kind_q;
  assign token_char_o    = out_char_q;
  assign heading_level_o = out_lvl_q;
  assign last_o          = out_last_q;

endmodule

[dv/tb_ifaces.sv]
`timescale 1ns / 100ps
// Channel interfaces live with the RTL; this file only holds the token record type.
package tb_tok_pkg;
  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] ch;
    logic [2:0]  lvl;
    logic        last;
  } tok_t;
endpackage

[dv/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  wmit_char_if char_if ();
  wmit_tok_if  tok_if ();

  wiki_markup_inline_tokenizer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if.sink),
    .tok_o  (tok_if.source)
  );

  tb_tok_pkg::tok_t tok_queue[$];
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  int   hold_off = 0;
  logic stall_en = 1'b1;

  // tokenizer state
  wmit_pkg::sym_e   run_sym = wmit_pkg::SYM_NONE;
  int unsigned      run_len = 0;
  int unsigned      em_st = 0, st_st = 0, in_para = 0, head_lvl = 0, held_eq = 0;
  tb_tok_pkg::tok_t step_toks[$];

  initial begin
    char_if.valid = 1'b0;
    char_if.code_point = '0;
    char_if.first_of_line = 1'b0;
    tok_if.ready = 1'b0;
  end

  function automatic void push_tok(logic [3:0] k, logic [15:0] c, int unsigned l);
    tb_tok_pkg::tok_t t;
    if (step_toks.size() >= wmit_pkg::MAX_TOKENS) return;
    t.kind = k; t.ch = c; t.lvl = l[2:0]; t.last = 1'b0;
    step_toks = {step_toks, t};
  endfunction

  function automatic void toggle_em();
    if (em_st != 0) begin em_st = 0; push_tok(wmit_pkg::TK_EM_CLOSE, '0, 0); end
    else begin em_st = (st_st != 0) ? 1 : 2; push_tok(wmit_pkg::TK_EM_OPEN, '0, 0); end
  endfunction

  function automatic void toggle_strong();
    if (st_st != 0) begin st_st = 0; push_tok(wmit_pkg::TK_STRONG_CLOSE, '0, 0); end
    else begin st_st = (em_st != 0) ? 1 : 2; push_tok(wmit_pkg::TK_STRONG_OPEN, '0, 0); end
  endfunction

  function automatic void clear_run();
    run_sym = wmit_pkg::SYM_NONE; run_len = 0;
  endfunction

  function automatic bit resolve_run();
    wmit_pkg::sym_e s;
    int unsigned n;
    s = run_sym; n = run_len;
    if (n == 0 || s == wmit_pkg::SYM_NONE) begin clear_run(); return 1'b0; end
    if (s == wmit_pkg::SYM_EQ) begin
      clear_run();
      if (n > wmit_pkg::MAX_HEADING_DEF) n = wmit_pkg::MAX_HEADING_DEF;
      head_lvl = n; held_eq = 0;
      push_tok(wmit_pkg::TK_HEAD_OPEN, '0, n);
      return 1'b1;
    end
    for (int i = 0; i < n / 2; i++) begin
      if (s == wmit_pkg::SYM_BSL) push_tok(wmit_pkg::TK_BREAK, '0, 0);
      else if (s == wmit_pkg::SYM_SL) toggle_em();
      else toggle_strong();
    end
    if (n % 2 == 1)
      push_tok(wmit_pkg::TK_LIT, s == wmit_pkg::SYM_BSL ? wmit_pkg::CH_BSL :
               (s == wmit_pkg::SYM_SL ? wmit_pkg::CH_SL : wmit_pkg::CH_STAR), 0);
    clear_run();
    return 1'b0;
  endfunction

  function automatic void flush_held(int reserve);
    for (int i = 0; i < held_eq; i++) begin
      if (step_toks.size() >= wmit_pkg::MAX_TOKENS - reserve) break;
      push_tok(wmit_pkg::TK_LIT, wmit_pkg::CH_EQ, 0);
    end
    held_eq = 0;
  endfunction

  function automatic void close_heading();
    push_tok(wmit_pkg::TK_HEAD_CLOSE, '0, head_lvl);
    head_lvl = 0; held_eq = 0;
  endfunction

  function automatic void heading_char(logic [15:0] c);
    if (c == wmit_pkg::CH_NL) close_heading();
    else if (c == wmit_pkg::CH_EQ) begin
      if (held_eq < wmit_pkg::MAX_RUN_DEF) held_eq++;
    end else begin
      flush_held(1);
      push_tok(wmit_pkg::TK_LIT, c, 0);
    end
  endfunction

  function automatic void normal_char(logic [15:0] c, bit fol);
    wmit_pkg::sym_e s;
    s = wmit_pkg::classify(c);
    if (s != wmit_pkg::SYM_NONE && s == run_sym && run_len > 0) begin
      if (s == wmit_pkg::SYM_EQ) begin
        run_len++;
        if (run_len > wmit_pkg::MAX_HEADING_DEF) begin
          for (int i = 0; i < run_len; i++) push_tok(wmit_pkg::TK_LIT, wmit_pkg::CH_EQ, 0);
          clear_run();
        end
      end else if (run_len < wmit_pkg::MAX_RUN_DEF) run_len++;
      return;
    end
    if (resolve_run()) begin heading_char(c); return; end
    if (s == wmit_pkg::SYM_EQ) begin
      if (fol) begin run_sym = wmit_pkg::SYM_EQ; run_len = 1; end
      else push_tok(wmit_pkg::TK_LIT, wmit_pkg::CH_EQ, 0);
    end else if (s != wmit_pkg::SYM_NONE) begin
      run_sym = s; run_len = 1;
    end else if (c != wmit_pkg::CH_NL) push_tok(wmit_pkg::TK_LIT, c, 0);
  endfunction

  function automatic void close_section();
    if (em_st > st_st) begin
      em_st = 0; push_tok(wmit_pkg::TK_EM_CLOSE, '0, 0);
      if (st_st != 0) begin st_st = 0; push_tok(wmit_pkg::TK_STRONG_CLOSE, '0, 0); end
    end else if (st_st > em_st) begin
      st_st = 0; push_tok(wmit_pkg::TK_STRONG_CLOSE, '0, 0);
      if (em_st != 0) begin em_st = 0; push_tok(wmit_pkg::TK_EM_CLOSE, '0, 0); end
    end else if (em_st != 0) begin
      em_st = 0; push_tok(wmit_pkg::TK_EM_CLOSE, '0, 0);
      st_st = 0; push_tok(wmit_pkg::TK_STRONG_CLOSE, '0, 0);
    end
    push_tok(wmit_pkg::TK_PARA_CLOSE, '0, 0);
    in_para = 0;
  endfunction

  function automatic void tokenize(logic [15:0] c, bit fol);
    step_toks.delete();
    if (fol) begin
      if (head_lvl != 0) flush_held(0);
      else if (run_len > 0) begin
        if (resolve_run()) heading_char(wmit_pkg::CH_NL);
      end
      clear_run();
    end
    if (fol && c == wmit_pkg::CH_NL) begin
      if (head_lvl != 0) close_heading();
      if (in_para != 0) close_section();
    end else begin
      if (in_para == 0) begin push_tok(wmit_pkg::TK_PARA_OPEN, '0, 0); in_para = 1; end
      if (head_lvl != 0) heading_char(c);
      else normal_char(c, fol);
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tok_queue = {tok_queue, step_toks[i]};
  endfunction

  int burst_left = 0;

  // valid stays high between beats of a burst; drop it only for a gap
  task automatic send_char(logic [15:0] c, bit fol);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        char_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    char_if.valid <= 1'b1;
    char_if.code_point <= c;
    char_if.first_of_line <= fol;
    tokenize(c, fol);
    do @(posedge clk_i); while (!char_if.ready);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]}, i == 0);
    send_char(wmit_pkg::CH_NL, s.len() == 0);
  endtask

  function automatic logic [15:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1: return wmit_pkg::CH_EQ;
      2: return wmit_pkg::CH_BSL;
      3: return wmit_pkg::CH_SL;
      4: return wmit_pkg::CH_STAR;
      5: return wmit_pkg::CH_NL;
      6: return 16'($urandom_range(0, 16'hFFFF));
      default: return 16'($urandom_range(16'h61, 16'h7A));
    endcase
  endfunction

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      tok_if.ready <= 1'b0;
    end else if (stall_en) tok_if.ready <= (cycle_cnt % 7 < 4) || ($urandom_range(0, 3) == 0);
    else tok_if.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    tb_tok_pkg::tok_t got, want;
    if (rst_ni && tok_if.valid && tok_if.ready) begin
      got = '{tok_if.token_kind, tok_if.token_char, tok_if.heading_level, tok_if.last};
      if (tok_queue.size() == 0) begin
        $display("%0t: unexpected token, expected none actual %h", $time, got);
        err_cnt++;
      end else begin
        want = tok_queue.pop_front();
        if (got.kind != want.kind)
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        if (got.ch != want.ch)
          $display("%0t: char expected %h actual %h", $time, want.ch, got.ch);
        if (got.lvl != want.lvl)
          $display("%0t: level expected %0d actual %0d", $time, want.lvl, got.lvl);
        if (got.last != want.last)
          $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
        if (got != want) err_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic test_directed();
    send_line("plain");
    send_line("**bold** //em// ***x /");
    send_line("a\\\\b\\\\\\c");
    send_line("== Head ==");
    send_line("===");
    send_line("=======x");
    send_line("");
    send_line("**//mix");
    send_line("");
    send_line("//**mix**//");
    send_line("");
    send_char(16'hFFFF, 1); send_char(16'h0000, 0);
    send_char(wmit_pkg::CH_STAR, 1); send_char(wmit_pkg::CH_STAR, 0);
    send_char(16'h41, 1);
    send_char(wmit_pkg::CH_EQ, 1); send_char(16'h42, 0);
    send_char(wmit_pkg::CH_EQ, 0); send_char(wmit_pkg::CH_EQ, 0);
    send_char(16'h43, 1);
    send_char(wmit_pkg::CH_NL, 1);
  endtask

  task automatic test_long_runs();
    for (int i = 0; i < 70; i++) send_char(wmit_pkg::CH_STAR, i == 0);
    send_char(wmit_pkg::CH_NL, 0);
    send_char(wmit_pkg::CH_EQ, 1); send_char(16'h61, 0);
    for (int i = 0; i < 70; i++) send_char(wmit_pkg::CH_EQ, 0);
    send_char(16'h62, 0);
    send_char(wmit_pkg::CH_NL, 0);
    send_char(wmit_pkg::CH_NL, 1);
  endtask

  task automatic test_random(int n_items);
    bit fol;
    for (int n = 0; n < n_items; n++) begin
      fol = ($urandom_range(0, 5) == 0);
      send_char(pick_char(), fol);
    end
    send_char(wmit_pkg::CH_NL, 1);
  endtask

  task automatic test_backpressure();
    fork
      hold_off = 300;
      for (int n = 0; n < 40; n++) send_char(pick_char(), $urandom_range(0, 4) == 0);
    join
    send_char(wmit_pkg::CH_NL, 1);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_long_runs();
    test_random(50);
    stall_en = 1'b0;
    test_random(50);
    stall_en = 1'b1;
    test_backpressure();
    char_if.valid <= 1'b0;
    while (tok_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && tok_queue.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule
